// File: src/wavenc_pkg.sv
// Package for the WAV PCM16 stream encoder: widths, constants, field codes
// and the float-to-PCM16 conversion function. No dependencies.
`default_nettype none
package wavenc_pkg;
	localparam int MaxChannelsDef = 16;
	localparam int FrameCountBitsDef = 26;
	localparam int HdrLen = 44;
	localparam int HdrIdxW = 6;
	localparam logic [30:0] CntMax = 31'h7FFF_FFFF;
	localparam logic CMD_HEADER = 1'b0;
	localparam logic CMD_SAMPLE = 1'b1;
	localparam logic [1:0] REG_CHANNELS = 2'd0;
	localparam logic [1:0] REG_RATE = 2'd1;
	localparam logic [1:0] REG_FRAMES = 2'd2;
	localparam logic [18:0] RateMin = 19'd8000;

	// Queue entry between front and back
	typedef struct packed {
		logic        is_hdr;
		logic [15:0] pcm;
	} job_t;

	// float bits -> PCM16, clamp to [-1,1], x32768 negative, x32767 else, trunc
	function automatic logic [15:0] f2pcm(input logic [31:0] f);
		logic        sgn;
		logic [7:0]  ex;
		logic [23:0] man;
		logic [39:0] prod;
		logic [39:0] sh;
		logic [15:0] mag;
		logic        rnd;
		sgn = f[31];
		ex = f[30:23];
		man = {1'b1, f[22:0]};
		prod = '0;
		sh = '0;
		mag = '0;
		rnd = 1'b0;
		if (ex == 8'hFF && f[22:0] != 23'd0) begin
			mag = 16'd0;
		end else if (ex >= 8'd127) begin
			mag = sgn ? 16'h8000 : 16'h7FFF;
		end else if (ex < 8'd103) begin
			mag = 16'd0;
		end else begin
			// value = man * 2^(ex-150); product by 32767 or 32768
			prod = sgn ? {man, 15'd0} : ({16'd0, man} * 40'd32767);
			// round the x32767 product to a 24-bit significand, nearest even
			if (!sgn) begin
				if (prod[38]) begin
					rnd = prod[14] && (prod[15] || (prod[13:0] != 14'd0));
					prod = {prod[39:15], 15'd0} + (rnd ? 40'h8000 : 40'd0);
				end else begin
					rnd = prod[13] && (prod[14] || (prod[12:0] != 13'd0));
					prod = {prod[39:14], 14'd0} + (rnd ? 40'h4000 : 40'd0);
				end
			end
			sh = prod >> (8'd150 - ex);
			mag = sh[15:0];
		end
		return sgn ? (16'd0 - mag) : mag;
	endfunction
endpackage
`default_nettype wire

// File: src/wavenc_front.sv
// Front end of the WAV encoder: accepts commands, applies the drop limit,
// converts samples and pushes jobs into the queue. Uses wavenc_pkg.
`default_nettype none
module wavenc_front import wavenc_pkg::*; #(
	parameter int FRAME_COUNT_BITS = FrameCountBitsDef
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        s_axis_tvalid,
	output logic                             s_axis_tready,
	input  wire logic [31:0]                 s_axis_tdata,
	input  wire logic                        s_axis_tuser,
	input  wire logic [4:0]                  chan,
	input  wire logic [FRAME_COUNT_BITS-1:0] frames,
	output logic                             push,
	output job_t                             push_job,
	input  wire logic                        q_full
);
	logic [30:0] cnt_q;
	logic [FRAME_COUNT_BITS+4:0] total;
	logic acc, drop;

	assign total = frames * chan;
	assign s_axis_tready = !q_full;
	assign acc = s_axis_tvalid && s_axis_tready;
	assign drop = ({{(FRAME_COUNT_BITS+5){1'b0}}, cnt_q} >= {31'd0, total})
		|| (cnt_q == CntMax);
	assign push = acc && (s_axis_tuser == CMD_HEADER || !drop);
	assign push_job.is_hdr = (s_axis_tuser == CMD_HEADER);
	assign push_job.pcm = f2pcm(s_axis_tdata);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (acc) begin
			if (s_axis_tuser == CMD_HEADER) cnt_q <= '0;
			else if (!drop) cnt_q <= cnt_q + 31'd1;
		end
	end
endmodule
`default_nettype wire

// File: src/wavenc_back.sv
// Back end of the WAV encoder: pops jobs and serializes header or sample
// bytes into a registered output stage. Uses wavenc_pkg.
`default_nettype none
module wavenc_back import wavenc_pkg::*; #(
	parameter int FRAME_COUNT_BITS = FrameCountBitsDef
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        q_valid,
	input  wire job_t                        q_job,
	output logic                             pop,
	input  wire logic [4:0]                  chan,
	input  wire logic [18:0]                 rate,
	input  wire logic [FRAME_COUNT_BITS-1:0] frames,
	output logic                             m_axis_tvalid,
	input  wire logic                        m_axis_tready,
	output logic [7:0]                       m_axis_tdata,
	output logic                             m_axis_tlast
);
	logic [HdrIdxW-1:0] idx_q;
	logic [7:0] byte_n;
	logic last_n, adv;
	logic [31:0] data_sz, riff_sz, brate;
	logic [15:0] chan16, balign;
	logic [31:0] rate32;

	assign data_sz = 32'((frames * chan) << 1);
	assign riff_sz = data_sz + 32'd36;
	assign brate = 32'((rate * chan) << 1);
	assign chan16 = {11'd0, chan};
	assign balign = {10'd0, chan, 1'b0};
	assign rate32 = {13'd0, rate};

	always_comb begin
		byte_n = 8'd0;
		if (q_job.is_hdr) begin
			case (idx_q)
				6'd0: byte_n = "R"; 6'd1: byte_n = "I"; 6'd2: byte_n = "F";
				6'd3: byte_n = "F";
				6'd4: byte_n = riff_sz[7:0]; 6'd5: byte_n = riff_sz[15:8];
				6'd6: byte_n = riff_sz[23:16]; 6'd7: byte_n = riff_sz[31:24];
				6'd8: byte_n = "W"; 6'd9: byte_n = "A"; 6'd10: byte_n = "V";
				6'd11: byte_n = "E"; 6'd12: byte_n = "f"; 6'd13: byte_n = "m";
				6'd14: byte_n = "t"; 6'd15: byte_n = " ";
				6'd16: byte_n = 8'd16; 6'd20: byte_n = 8'd1;
				6'd22: byte_n = chan16[7:0]; 6'd23: byte_n = chan16[15:8];
				6'd24: byte_n = rate32[7:0]; 6'd25: byte_n = rate32[15:8];
				6'd26: byte_n = rate32[23:16]; 6'd27: byte_n = rate32[31:24];
				6'd28: byte_n = brate[7:0]; 6'd29: byte_n = brate[15:8];
				6'd30: byte_n = brate[23:16]; 6'd31: byte_n = brate[31:24];
				6'd32: byte_n = balign[7:0]; 6'd33: byte_n = balign[15:8];
				6'd34: byte_n = 8'd16;
				6'd36: byte_n = "d"; 6'd37: byte_n = "a"; 6'd38: byte_n = "t";
				6'd39: byte_n = "a";
				6'd40: byte_n = data_sz[7:0]; 6'd41: byte_n = data_sz[15:8];
				6'd42: byte_n = data_sz[23:16]; 6'd43: byte_n = data_sz[31:24];
				default: byte_n = 8'd0;
			endcase
			last_n = (idx_q == HdrIdxW'(HdrLen - 1));
		end else begin
			byte_n = idx_q[0] ? q_job.pcm[15:8] : q_job.pcm[7:0];
			last_n = idx_q[0];
		end
	end

	// output register advances when empty or taken
	assign adv = q_valid && (!m_axis_tvalid || m_axis_tready);
	assign pop = adv && last_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			m_axis_tvalid <= 1'b0;
		end else begin
			if (adv) begin
				m_axis_tvalid <= 1'b1;
				idx_q <= last_n ? '0 : idx_q + 6'd1;
			end else if (m_axis_tready) begin
				m_axis_tvalid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			m_axis_tdata <= byte_n;
			m_axis_tlast <= last_n;
		end
	end
endmodule
`default_nettype wire

// File: src/wav_pcm16_stream_encoder.sv
// Top level of the WAV PCM16 stream encoder: config registers, job queue,
// front and back ends. Uses wavenc_pkg, wavenc_front, wavenc_back.
//
// A header command (tuser 0) yields 44 bytes, a sample command (tuser 1)
// yields two bytes, low byte first, or none once the frame budget is spent.
// The output emits one byte per cycle while the receiver keeps tready high;
// a four-entry job queue lets the input keep accepting while the byte
// serializer drains. tlast marks the final byte of each command.
`default_nettype none
module wav_pcm16_stream_encoder import wavenc_pkg::*; #(
	parameter int MAX_CHANNELS = MaxChannelsDef,
	parameter int FRAME_COUNT_BITS = FrameCountBitsDef
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [31:0] s_axis_tdata,  // sample_bits
	input  wire logic        s_axis_tuser,  // command
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [7:0]       m_axis_tdata,  // out_byte
	output logic             m_axis_tlast,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_addr,
	input  wire logic [25:0] cfg_wdata
);
	localparam int QD = 4;
	localparam logic [4:0] ChMax = (MAX_CHANNELS > 31) ? 5'd31 : 5'(MAX_CHANNELS);

	logic [4:0] chan_q;
	logic [18:0] rate_q;
	logic [FRAME_COUNT_BITS-1:0] frames_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chan_q <= 5'd1;
			rate_q <= RateMin;
			frames_q <= '0;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_CHANNELS: chan_q <= (cfg_wdata[4:0] == 5'd0) ? 5'd1 :
					(cfg_wdata[4:0] > ChMax) ? ChMax : cfg_wdata[4:0];
				REG_RATE: rate_q <= (cfg_wdata[18:0] < RateMin) ? RateMin : cfg_wdata[18:0];
				REG_FRAMES: frames_q <= cfg_wdata[FRAME_COUNT_BITS-1:0];
				default: ;
			endcase
		end
	end

	job_t q_mem [QD];
	logic [1:0] wp_q, rp_q;
	logic [2:0] cnt_q;
	logic push, pop;
	job_t push_job;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 2'd1;
			if (pop) rp_q <= rp_q + 2'd1;
			cnt_q <= cnt_q + {2'd0, push} - {2'd0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) q_mem[wp_q] <= push_job;
	end

	wavenc_front #(.FRAME_COUNT_BITS(FRAME_COUNT_BITS)) u_front (
		.clk, .arst_n, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
		.s_axis_tuser, .chan(chan_q), .frames(frames_q), .push, .push_job,
		.q_full(cnt_q == 3'(QD))
	);

	wavenc_back #(.FRAME_COUNT_BITS(FRAME_COUNT_BITS)) u_back (
		.clk, .arst_n, .q_valid(cnt_q != 3'd0), .q_job(q_mem[rp_q]), .pop,
		.chan(chan_q), .rate(rate_q), .frames(frames_q), .m_axis_tvalid,
		.m_axis_tready, .m_axis_tdata, .m_axis_tlast
	);
endmodule
`default_nettype wire

// File: sim/wav_pcm16_stream_encoder_tb.sv
// Testbench for the WAV PCM16 stream encoder: header bytes, sample scaling,
// frame budget drops and register saturation, with random stalls on both sides.
// Depends on wavenc_pkg and the RTL top level wav_pcm16_stream_encoder.
`default_nettype none
module wav_pcm16_stream_encoder_tb import wavenc_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [7:0] data;
		logic       last;
	} byte_exp_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata = '0;
	logic        s_axis_tuser = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [7:0]  m_axis_tdata;
	logic        m_axis_tlast;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_addr = '0;
	logic [25:0] cfg_wdata = '0;

	// Encoder state as the block should hold it
	logic [4:0]  chan_cnt;
	logic [18:0] rate_hz;
	logic [25:0] frames;
	logic [30:0] samples_out;

	byte_exp_t   file_bytes_q[$];
	int          errors = 0;
	int          burst_left = 0;
	int          stall_mode = 0;

	wav_pcm16_stream_encoder u_dut (.*);

	always #5 clk = ~clk;

	// Receiver stall pattern: switch modes now and then
	always @(posedge clk) begin
		if ($urandom_range(0, 99) == 0) stall_mode <= $urandom_range(0, 3);
		case (stall_mode)
			0: m_axis_tready <= 1'b1;
			1: m_axis_tready <= ($urandom_range(0, 3) != 0);
			2: m_axis_tready <= 1'($urandom_range(0, 1));
			default: m_axis_tready <= ($urandom_range(0, 7) == 0);
		endcase
	end

	always @(posedge clk) begin
		byte_exp_t e;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (file_bytes_q.size() == 0) begin
				$display("%0t: unexpected item data=%h last=%b", $time, m_axis_tdata,
					m_axis_tlast);
				errors++;
			end else begin
				e = file_bytes_q.pop_front();
				if (e.data !== m_axis_tdata) begin
					$display("%0t: byte mismatch expected %h actual %h", $time, e.data,
						m_axis_tdata);
					errors++;
				end
				if (e.last !== m_axis_tlast) begin
					$display("%0t: tlast mismatch expected %b actual %b", $time, e.last,
						m_axis_tlast);
					errors++;
				end
			end
		end
	end

	// Single-precision product, rounded to nearest even, then truncated toward zero
	function automatic logic [15:0] float_to_pcm(input logic [31:0] f);
		logic [7:0]  e;
		logic [23:0] m;
		logic [39:0] p, mask, half, rem;
		logic [15:0] mag;
		int          drop_n;
		e = f[30:23];
		m = {1'b1, f[22:0]};
		if (e == 8'hFF && f[22:0] != 23'd0) return 16'd0;
		if (e >= 8'd127) return f[31] ? 16'h8000 : 16'h7FFF;
		if (e < 8'd103) return 16'd0;
		if (f[31]) begin
			p = {m, 15'd0};
		end else begin
			p = 40'(m) * 40'd32767;
			drop_n = p[38] ? 15 : 14;
			mask = (40'd1 << drop_n) - 40'd1;
			half = 40'd1 << (drop_n - 1);
			rem = p & mask;
			p = p & ~mask;
			if (rem > half || (rem == half && p[drop_n])) p = p + (40'd1 << drop_n);
		end
		mag = 16'(p >> (150 - int'(e)));
		return f[31] ? (16'd0 - mag) : mag;
	endfunction

	task automatic queue_bytes(input logic [7:0] b[], input int n);
		byte_exp_t e;
		for (int k = 0; k < n; k++) begin
			e.data = b[k];
			e.last = (k == n - 1);
			file_bytes_q.insert(file_bytes_q.size(), e);
		end
	endtask

	task automatic predict_item(input logic cmd, input logic [31:0] bits);
		logic [7:0] b[];
		logic [63:0] tot;
		logic [31:0] dsz, brate, w[11];
		logic [15:0] pcm;
		tot = 64'(frames) * 64'(chan_cnt);
		if (cmd == CMD_HEADER) begin
			dsz = 32'(tot * 2);
			brate = 32'(64'(rate_hz) * 64'(chan_cnt) * 2);
			w[0] = 32'h4646_4952;
			w[1] = 32'd36 + dsz;
			w[2] = 32'h4556_4157;
			w[3] = 32'h2074_6d66;
			w[4] = 32'd16;
			w[5] = {16'(chan_cnt), 16'd1};
			w[6] = 32'(rate_hz);
			w[7] = brate;
			w[8] = {16'd16, 16'(chan_cnt) * 16'd2};
			w[9] = 32'h6174_6164;
			w[10] = dsz;
			b = new[HdrLen];
			for (int i = 0; i < HdrLen; i++) b[i] = w[i / 4][8 * (i % 4) +: 8];
			queue_bytes(b, HdrLen);
			samples_out = '0;
		end else if (64'(samples_out) < tot && samples_out != CntMax) begin
			pcm = float_to_pcm(bits);
			b = new[2];
			b[0] = pcm[7:0];
			b[1] = pcm[15:8];
			queue_bytes(b, 2);
			samples_out = samples_out + 31'd1;
		end
	endtask

	task automatic send_item(input logic cmd, input logic [31:0] bits);
		if (burst_left == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 20);
		end else begin
			burst_left--;
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= cmd;
		s_axis_tdata <= bits;
		predict_item(cmd, bits);
		do @(posedge clk); while (!s_axis_tready);
	endtask

	task automatic drain();
		int guard = 0;
		s_axis_tvalid <= 1'b0;
		while (file_bytes_q.size() != 0 && guard < 200000) begin
			@(posedge clk);
			guard++;
		end
		// wait a little so stray extra bytes get caught
		repeat (60) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [25:0] val);
		logic [31:0] v;
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_CHANNELS: begin
				v = {27'd0, val[4:0]};
				chan_cnt = v < 1 ? 5'd1 : (v > MaxChannelsDef ? 5'(MaxChannelsDef) : v[4:0]);
			end
			REG_RATE: rate_hz = val[18:0] < RateMin ? RateMin : val[18:0];
			REG_FRAMES: frames = val;
			default: ;
		endcase
	endtask

	task automatic test_directed();
		logic [31:0] pts[] = '{32'h0000_0000, 32'h8000_0000, 32'h3F80_0000, 32'hBF80_0000,
			32'h7F80_0000, 32'hFF80_0000, 32'h7FC0_0001, 32'hFFFF_FFFF, 32'h3F00_0000,
			32'hBF00_0000, 32'h4000_0000, 32'hC700_0000, 32'h3380_0000, 32'h3F7F_FFFF,
			32'hBF7F_FFFF, 32'h0000_0001};
		write_reg(REG_CHANNELS, 26'd2);
		write_reg(REG_RATE, 26'd44100);
		write_reg(REG_FRAMES, 26'd7);
		send_item(CMD_HEADER, 32'hFFFF_FFFF);
		foreach (pts[i]) send_item(CMD_SAMPLE, pts[i]);
		drain();
	endtask

	task automatic test_register_extremes();
		write_reg(REG_CHANNELS, 26'd0);
		write_reg(REG_RATE, 26'd0);
		write_reg(REG_FRAMES, 26'h3FF_FFFF);
		send_item(CMD_HEADER, '0);
		drain();
		write_reg(REG_CHANNELS, 26'h3FF_FFFF);
		write_reg(REG_RATE, 26'h7_FFFF);
		send_item(CMD_HEADER, '0);
		drain();
		write_reg(REG_CHANNELS, 26'd17);
		write_reg(REG_RATE, 26'd7999);
		write_reg(REG_FRAMES, 26'd0);
		send_item(CMD_HEADER, '0);
		send_item(CMD_SAMPLE, 32'h3F80_0000);
		drain();
	endtask

	task automatic test_random_streams();
		logic [31:0] bits;
		for (int ph = 0; ph < 6; ph++) begin
			write_reg(REG_CHANNELS, 26'($urandom_range(0, 31)));
			write_reg(REG_RATE, 26'($urandom_range(0, 19'h7FFFF)));
			write_reg(REG_FRAMES, 26'($urandom_range(1, 30)));
			send_item(CMD_HEADER, $urandom);
			repeat (65) begin
				bits = $urandom;
				case ($urandom_range(0, 9))
					0: bits = $urandom;
					1: send_item(CMD_HEADER, $urandom);
					2: bits = {1'($urandom_range(0, 1)), 8'hFF, 23'($urandom)};
					default: bits = {1'($urandom_range(0, 1)), 8'($urandom_range(100, 128)),
						23'($urandom)};
				endcase
				send_item(CMD_SAMPLE, bits);
			end
			drain();
		end
	endtask

	initial begin
		chan_cnt = 5'd1;
		rate_hz = RateMin;
		frames = '0;
		samples_out = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_register_extremes();
		test_random_streams();
		if (errors == 0 && file_bytes_q.size() == 0)
			$display("wav_pcm16_stream_encoder_tb: done, clean");
		else
			$display("wav_pcm16_stream_encoder_tb: done, errors");
		$finish;
	end

	initial begin
		#20ms;
		$display("wav_pcm16_stream_encoder_tb: done, errors");
		$finish;
	end
endmodule
`default_nettype wire
